// ----- rtl/core/ir_pulse_width_transceiver_assert.svh -----
// Assertion macros used by the infrared pulse-width transceiver RTL.
`ifndef IR_PULSE_WIDTH_TRANSCEIVER_ASSERT_SVH
`define IR_PULSE_WIDTH_TRANSCEIVER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define IRPW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define IRPW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/irpw_pkg.sv -----
// Types, codes and helper functions of the infrared pulse-width transceiver.
`timescale 1ns / 1ps
package irpw_pkg;

  // Frame and counter sizes
  localparam int TX_FRAME_LENGTH = 23;
  localparam int RX_FRAME_DEPTH  = 15;
  localparam int INTERVAL_BITS   = 12;
  localparam int TX_POS_W        = 5;
  localparam int TX_ELAPSED_W    = 7;
  localparam int RX_POS_W        = $clog2(RX_FRAME_DEPTH + 1);
  localparam int RX_IDX_W        = $clog2(RX_FRAME_DEPTH);
  localparam int CENTER_W        = 12;
  localparam int TOL_W           = 8;
  localparam int CFG_DATA_W      = 12;
  localparam int CFG_IDX_W       = 3;
  localparam int CMP_W = ((INTERVAL_BITS > CENTER_W) ? INTERVAL_BITS : CENTER_W) + 1;

  typedef logic [2:0] sym_t;
  typedef logic [1:0] cmd_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Symbol codes (divider shares its code with unknown)
  localparam sym_t SYM_ZERO    = 3'd0;
  localparam sym_t SYM_ONE     = 3'd1;
  localparam sym_t SYM_START   = 3'd2;
  localparam sym_t SYM_STOP    = 3'd3;
  localparam sym_t SYM_DIVIDER = 3'd4;
  localparam sym_t SYM_UNKNOWN = 3'd4;

  // Commands
  localparam cmd_t CMD_TICK = 2'd0;
  localparam cmd_t CMD_EDGE = 2'd1;
  localparam cmd_t CMD_SEND = 2'd2;

  // Register indexes
  localparam cfg_idx_t REG_ZERO_CENTER  = 3'd0;
  localparam cfg_idx_t REG_ONE_CENTER   = 3'd1;
  localparam cfg_idx_t REG_START_CENTER = 3'd2;
  localparam cfg_idx_t REG_STOP_CENTER  = 3'd3;
  localparam cfg_idx_t REG_TOL_ABOVE    = 3'd4;
  localparam cfg_idx_t REG_TOL_BELOW    = 3'd5;

  // Register reset values
  localparam logic [CENTER_W-1:0] RST_ZERO_CENTER  = 12'd43;
  localparam logic [CENTER_W-1:0] RST_ONE_CENTER   = 12'd65;
  localparam logic [CENTER_W-1:0] RST_START_CENTER = 12'd90;
  localparam logic [CENTER_W-1:0] RST_STOP_CENTER  = 12'd110;
  localparam logic [TOL_W-1:0]    RST_TOL          = 8'd3;

  // Symbol at a frame position, derived from the latched byte.
  // Odd positions are dividers; even positions carry start, data, parity,
  // stop and the trailing mark.
  function automatic sym_t tx_symbol(input logic [TX_POS_W-1:0] pos,
                                     input logic [7:0] data);
    logic [3:0] slot;
    logic [3:0] bit_idx;
    sym_t       sym;
    slot    = pos[TX_POS_W-1:1];
    bit_idx = slot - 4'd1;
    if (pos[0]) begin
      sym = SYM_DIVIDER;
    end else begin
      case (slot)
        4'd0:                    sym = SYM_START;
        4'd1, 4'd2, 4'd3, 4'd4,
        4'd5, 4'd6, 4'd7, 4'd8:  sym = {2'b00, data[bit_idx[2:0]]};
        4'd9:                    sym = {2'b00, data[0]};
        4'd10:                   sym = SYM_STOP;
        default:                 sym = SYM_ZERO;
      endcase
    end
    return sym;
  endfunction

  // Duration of a transmit symbol in carrier ticks.
  function automatic logic [TX_ELAPSED_W-1:0] symbol_ticks(input sym_t sym);
    logic [TX_ELAPSED_W-1:0] n;
    case (sym)
      SYM_ZERO:  n = 7'd20;
      SYM_ONE:   n = 7'd40;
      SYM_START: n = 7'd60;
      SYM_STOP:  n = 7'd80;
      default:   n = 7'd20;
    endcase
    return n;
  endfunction

  // center - below <= t <= center + above, evaluated without wrap.
  function automatic logic in_window(input logic [INTERVAL_BITS-1:0] t,
                                     input logic [CENTER_W-1:0] center,
                                     input logic [TOL_W-1:0] above,
                                     input logic [TOL_W-1:0] below);
    logic [CMP_W-1:0] tx;
    logic [CMP_W-1:0] cx;
    logic [CMP_W-1:0] hi;
    logic [CMP_W-1:0] lo_sum;
    tx     = CMP_W'(t);
    cx     = CMP_W'(center);
    hi     = cx + CMP_W'(above);
    lo_sum = tx + CMP_W'(below);
    return (tx <= hi) && (lo_sum >= cx);
  endfunction

endpackage

// ----- rtl/core/ir_pulse_width_transceiver.sv -----
// Infrared pulse-width transceiver: transmit sequencer, edge classifier, receive frame.
//
//  Channel | Direction | Handshake         | Payload
//  --------+-----------+-------------------+---------------------------------------
//  in      | slave     | in_tvalid/tready  | tuser: command; tdata: send_byte
//  out     | master    | out_tvalid/tready | tuser: symbol_valid, byte_valid; tdata: status
//  cfg     | write     | cfg_wr_en         | cfg_index, cfg_wdata (no read-back)
//
// Every accepted word updates the link state in the same cycle and lands its
// result in the output register; one word per cycle in, one result per cycle
// out while the output is not stalled; out_tvalid rises in the cycle after input accept.
// The output register is the only buffer: in_tready drops only while a result
// sits there and the downstream side holds out_tready low.
// rst_n is synchronous, active low; it clears all control state and the
// receive frame, and loads the register reset values. No clearing pass.
`timescale 1ns / 1ps
`include "ir_pulse_width_transceiver_assert.svh"

module ir_pulse_width_transceiver (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input words
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [7:0]                           in_tdata,   // [7:0] send_byte
  input  logic [1:0]                           in_tuser,   // [1:0] command
  // Result words
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [0] carrier_on, [1] tx_busy, [2] send_rejected, [5:3] symbol_kind,
  // [13:6] received_byte, [14] parity_ok, [15] zero fill
  output logic [15:0]                          out_tdata,
  output logic [1:0]                           out_tuser,  // [0] symbol_valid, [1] byte_valid
  // Configuration writes
  input  logic                                 cfg_wr_en,
  input  logic [irpw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [irpw_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import irpw_pkg::*;

  // Configuration registers
  logic [CENTER_W-1:0] zero_center_r, one_center_r, start_center_r, stop_center_r;
  logic [TOL_W-1:0]    tol_above_r, tol_below_r;

  // Transmit state: the frame is rebuilt from the latched byte per position
  logic [7:0]              tx_byte_r, tx_byte_nxt;
  logic [TX_POS_W-1:0]     tx_pos_r, tx_pos_nxt;
  logic [TX_ELAPSED_W-1:0] tx_elapsed_r, tx_elapsed_nxt;
  logic                    tx_active_r, tx_active_nxt;
  logic                    carrier_r, carrier_nxt;

  // Receive state
  logic [INTERVAL_BITS-1:0] ticks_r, ticks_nxt;
  sym_t                     rx_sym_r   [RX_FRAME_DEPTH];
  sym_t                     rx_sym_nxt [RX_FRAME_DEPTH];
  logic [RX_POS_W-1:0]      rx_pos_r, rx_pos_nxt;

  // Output register
  logic        out_valid_r;
  logic [15:0] out_data_r, out_data_nxt;
  logic [1:0]  out_user_r, out_user_nxt;

  // Per-word working values
  logic                    in_acc;
  cmd_t                    cmd;
  sym_t                    cur_sym;
  logic [TX_ELAPSED_W-1:0] elapsed_inc;
  sym_t                    edge_kind;
  sym_t                    kind;
  logic [RX_POS_W-1:0]     wr_pos;
  logic                    rejected, sym_valid, byte_valid, par_ok;
  logic [7:0]              rx_byte;

  assign cmd       = in_tuser;
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // Current transmit symbol and its tick count
  assign cur_sym     = tx_symbol(tx_pos_r, tx_byte_r);
  assign elapsed_inc = tx_elapsed_r + TX_ELAPSED_W'(1);

  // Sort the interval since the last edge; first matching window wins
  always_comb begin
    if (in_window(ticks_r, zero_center_r, tol_above_r, tol_below_r)) begin
      edge_kind = SYM_ZERO;
    end else if (in_window(ticks_r, one_center_r, tol_above_r, tol_below_r)) begin
      edge_kind = SYM_ONE;
    end else if (in_window(ticks_r, start_center_r, tol_above_r, tol_below_r)) begin
      edge_kind = SYM_START;
    end else if (in_window(ticks_r, stop_center_r, tol_above_r, tol_below_r)) begin
      edge_kind = SYM_STOP;
    end else begin
      edge_kind = SYM_UNKNOWN;
    end
  end

  // Next-state logic for one word
  always_comb begin
    tx_byte_nxt    = tx_byte_r;
    tx_pos_nxt     = tx_pos_r;
    tx_elapsed_nxt = tx_elapsed_r;
    tx_active_nxt  = tx_active_r;
    carrier_nxt    = carrier_r;
    ticks_nxt      = ticks_r;
    rx_sym_nxt     = rx_sym_r;
    rx_pos_nxt     = rx_pos_r;
    rejected       = 1'b0;
    sym_valid      = 1'b0;
    byte_valid     = 1'b0;
    par_ok         = 1'b0;
    kind           = SYM_ZERO;
    rx_byte        = 8'd0;
    wr_pos         = rx_pos_r;

    unique case (cmd)
      CMD_TICK: begin
        // Saturate the edge interval
        if (ticks_r != {INTERVAL_BITS{1'b1}}) begin
          ticks_nxt = ticks_r + INTERVAL_BITS'(1);
        end
        if (tx_active_r) begin
          tx_elapsed_nxt = elapsed_inc;
          if (elapsed_inc >= symbol_ticks(cur_sym)) begin
            // Symbol time is up: carrier on after a divider, off otherwise
            carrier_nxt    = (cur_sym == SYM_DIVIDER);
            tx_elapsed_nxt = '0;
            if (tx_pos_r == TX_POS_W'(TX_FRAME_LENGTH - 1)) begin
              tx_pos_nxt    = '0;
              tx_active_nxt = 1'b0;
              carrier_nxt   = 1'b0;
            end else begin
              tx_pos_nxt = tx_pos_r + TX_POS_W'(1);
            end
          end
        end
      end
      CMD_EDGE: begin
        ticks_nxt = '0;
        kind      = edge_kind;
        sym_valid = 1'b1;
        // A start symbol restarts the frame
        if (edge_kind == SYM_START) begin
          wr_pos = '0;
        end
        if (wr_pos < RX_POS_W'(RX_FRAME_DEPTH)) begin
          rx_sym_nxt[wr_pos[RX_IDX_W-1:0]] = edge_kind;
          rx_pos_nxt = wr_pos + RX_POS_W'(1);
        end
        if (edge_kind == SYM_STOP) begin
          byte_valid = 1'b1;
          for (int i = 0; i < 8; i++) begin
            rx_byte[i] = (rx_sym_nxt[i+1] == SYM_ONE);
          end
          par_ok = (rx_sym_nxt[9] == {2'b00, rx_byte[0]});
        end
      end
      CMD_SEND: begin
        if (tx_active_r) begin
          rejected = 1'b1;
        end else begin
          tx_byte_nxt    = in_tdata;
          tx_pos_nxt     = '0;
          tx_elapsed_nxt = '0;
          tx_active_nxt  = 1'b1;
          carrier_nxt    = 1'b1;
        end
      end
      default: begin
        // Unused command: report status only
      end
    endcase

    out_data_nxt = {1'b0, par_ok, rx_byte, kind, rejected, tx_active_nxt, carrier_nxt};
    out_user_nxt = {byte_valid, sym_valid};
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_center_r  <= RST_ZERO_CENTER;
      one_center_r   <= RST_ONE_CENTER;
      start_center_r <= RST_START_CENTER;
      stop_center_r  <= RST_STOP_CENTER;
      tol_above_r    <= RST_TOL;
      tol_below_r    <= RST_TOL;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ZERO_CENTER:  zero_center_r  <= cfg_wdata[CENTER_W-1:0];
        REG_ONE_CENTER:   one_center_r   <= cfg_wdata[CENTER_W-1:0];
        REG_START_CENTER: start_center_r <= cfg_wdata[CENTER_W-1:0];
        REG_STOP_CENTER:  stop_center_r  <= cfg_wdata[CENTER_W-1:0];
        REG_TOL_ABOVE:    tol_above_r    <= cfg_wdata[TOL_W-1:0];
        REG_TOL_BELOW:    tol_below_r    <= cfg_wdata[TOL_W-1:0];
        default: begin
          // Drop writes beyond the register list
        end
      endcase
    end
  end

  // Link state: advance only on an accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_pos_r     <= '0;
      tx_elapsed_r <= '0;
      tx_active_r  <= 1'b0;
      carrier_r    <= 1'b0;
      ticks_r      <= '0;
      rx_pos_r     <= '0;
      for (int i = 0; i < RX_FRAME_DEPTH; i++) begin
        rx_sym_r[i] <= SYM_ZERO;
      end
    end else if (in_acc) begin
      tx_pos_r     <= tx_pos_nxt;
      tx_elapsed_r <= tx_elapsed_nxt;
      tx_active_r  <= tx_active_nxt;
      carrier_r    <= carrier_nxt;
      ticks_r      <= ticks_nxt;
      rx_pos_r     <= rx_pos_nxt;
      rx_sym_r     <= rx_sym_nxt;
    end
  end

  // Latched send byte: payload, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      tx_byte_r <= tx_byte_nxt;
    end
  end

  // Output register: hold while stalled, load on every accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  // Checks
  `IRPW_ASSERT_NOW(a_byte_is_stop, out_valid_r && out_user_r[1],
    out_user_r[0] && (out_data_r[5:3] == SYM_STOP), "byte reported without a stop symbol")
  `IRPW_ASSERT_NOW(a_idle_tx_cleared, !tx_active_r,
    (tx_pos_r == '0) && (tx_elapsed_r == '0) && !carrier_r, "idle transmitter not cleared")
  `IRPW_ASSERT_NOW(a_rx_pos_bound, 1'b1,
    rx_pos_r <= RX_POS_W'(RX_FRAME_DEPTH), "receive position beyond frame depth")
  `IRPW_ASSERT_NEXT(a_send_starts, in_acc && (cmd == CMD_SEND) && !tx_active_r,
    tx_active_r && carrier_r && (tx_pos_r == '0), "accepted send did not start a frame")

endmodule

// ----- sim/irpw_result_checker.sv -----
// Result checker for the infrared pulse-width transceiver: mirrors the link state, compares results.
`timescale 1ns / 1ps

module irpw_result_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] send_byte
  input  logic [1:0]                        in_tuser,   // [1:0] command
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] carrier_on, [1] tx_busy, [2] send_rejected, [5:3] symbol_kind,
  // [13:6] received_byte, [14] parity_ok, [15] zero fill
  input  logic [15:0]                       out_tdata,
  input  logic [1:0]                        out_tuser,  // [0] symbol_valid, [1] byte_valid
  input  logic                              cfg_wr_en,
  input  logic [irpw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [irpw_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output int                                fail_count,
  output int                                pending
);
  import irpw_pkg::*;

  typedef struct packed {
    logic       carrier;
    logic       busy;
    logic       rejected;
    logic       sym_valid;
    sym_t       kind;
    logic       byte_valid;
    logic [7:0] rx_byte;
    logic       parity_ok;
  } link_status_t;

  link_status_t status_due[$];

  // Window settings
  logic [CENTER_W-1:0] ctr_zero, ctr_one, ctr_start, ctr_stop;
  logic [TOL_W-1:0]    tol_above, tol_below;

  // Transmit side
  sym_t                tx_frame [TX_FRAME_LENGTH];
  logic [4:0]          tx_pos;
  logic [6:0]          tx_ticks;
  logic                tx_on;
  logic                carrier;

  // Receive side
  logic [INTERVAL_BITS-1:0] since_edge;
  sym_t                     rx_frame [RX_FRAME_DEPTH];
  logic [RX_POS_W-1:0]      rx_pos;

  function automatic void reset_link();
    ctr_zero   = RST_ZERO_CENTER;
    ctr_one    = RST_ONE_CENTER;
    ctr_start  = RST_START_CENTER;
    ctr_stop   = RST_STOP_CENTER;
    tol_above  = RST_TOL;
    tol_below  = RST_TOL;
    tx_pos     = '0;
    tx_ticks   = '0;
    tx_on      = 1'b0;
    carrier    = 1'b0;
    since_edge = '0;
    rx_pos     = '0;
    for (int i = 0; i < TX_FRAME_LENGTH; i++) tx_frame[i] = SYM_ZERO;
    for (int i = 0; i < RX_FRAME_DEPTH; i++) rx_frame[i] = SYM_ZERO;
  endfunction

  function automatic void write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_ZERO_CENTER:  ctr_zero  = val[CENTER_W-1:0];
      REG_ONE_CENTER:   ctr_one   = val[CENTER_W-1:0];
      REG_START_CENTER: ctr_start = val[CENTER_W-1:0];
      REG_STOP_CENTER:  ctr_stop  = val[CENTER_W-1:0];
      REG_TOL_ABOVE:    tol_above = val[TOL_W-1:0];
      REG_TOL_BELOW:    tol_below = val[TOL_W-1:0];
      default: ;
    endcase
  endfunction

  // Carrier ticks each transmit symbol lasts; dividers share the zero length.
  function automatic logic [6:0] span_of(input sym_t s);
    logic [6:0] n;
    n = 7'd20;
    if (s == SYM_ONE)   n = 7'd40;
    if (s == SYM_START) n = 7'd60;
    if (s == SYM_STOP)  n = 7'd80;
    return n;
  endfunction

  function automatic logic hits(input int t, input int center);
    return (t <= center + int'(tol_above)) && (t + int'(tol_below) >= center);
  endfunction

  // First matching window wins.
  function automatic sym_t sort_interval(input int t);
    if (hits(t, int'(ctr_zero)))  return SYM_ZERO;
    if (hits(t, int'(ctr_one)))   return SYM_ONE;
    if (hits(t, int'(ctr_start))) return SYM_START;
    if (hits(t, int'(ctr_stop)))  return SYM_STOP;
    return SYM_UNKNOWN;
  endfunction

  function automatic void load_frame(input logic [7:0] b);
    for (int p = 0; p < TX_FRAME_LENGTH; p++) tx_frame[p] = p[0] ? SYM_DIVIDER : SYM_ZERO;
    tx_frame[0] = SYM_START;
    for (int i = 0; i < 8; i++) tx_frame[2 + 2 * i] = {2'b00, b[i]};
    tx_frame[18] = {2'b00, b[0]};
    tx_frame[20] = SYM_STOP;
    tx_pos   = '0;
    tx_ticks = '0;
    tx_on    = 1'b1;
    carrier  = 1'b1;
  endfunction

  function automatic void advance_tx();
    sym_t cur;
    if (!tx_on) return;
    if (tx_pos >= TX_FRAME_LENGTH) begin
      tx_on   = 1'b0;
      tx_pos  = '0;
      carrier = 1'b0;
      return;
    end
    cur      = tx_frame[tx_pos];
    tx_ticks = tx_ticks + 7'd1;
    if (tx_ticks >= span_of(cur)) begin
      carrier  = (cur == SYM_DIVIDER);
      tx_pos   = tx_pos + 5'd1;
      tx_ticks = '0;
    end
    if (tx_pos >= TX_FRAME_LENGTH) begin
      tx_pos  = '0;
      tx_on   = 1'b0;
      carrier = 1'b0;
    end
  endfunction

  function automatic link_status_t step_link(input cmd_t cmd, input logic [7:0] data);
    link_status_t r;
    r = '0;
    case (cmd)
      CMD_TICK: begin
        if (since_edge != {INTERVAL_BITS{1'b1}}) since_edge = since_edge + 1'b1;
        advance_tx();
      end
      CMD_EDGE: begin
        r.kind      = sort_interval(int'(since_edge));
        r.sym_valid = 1'b1;
        since_edge  = '0;
        if (r.kind == SYM_START) rx_pos = '0;
        if (rx_pos < RX_FRAME_DEPTH) begin
          rx_frame[rx_pos] = r.kind;
          rx_pos = rx_pos + 1'b1;
        end
        if (r.kind == SYM_STOP) begin
          r.byte_valid = 1'b1;
          for (int i = 0; i < 8; i++) r.rx_byte[i] = (rx_frame[i + 1] == SYM_ONE);
          r.parity_ok = (rx_frame[9] == {2'b00, r.rx_byte[0]});
        end
      end
      CMD_SEND: begin
        if (tx_on) r.rejected = 1'b1;
        else load_frame(data);
      end
      default: ;
    endcase
    r.carrier = carrier;
    r.busy    = tx_on;
    return r;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    link_status_t want;
    if (!rst_n) begin
      reset_link();
      status_due.delete();
      pending <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (status_due.size() == 0) begin
          $display("%0t ns: unexpected result word, expected none actual tdata %h tuser %b",
                   $time, out_tdata, out_tuser);
          fail_count++;
        end else begin
          want = status_due.pop_front();
          check_field("carrier_on", want.carrier, out_tdata[0]);
          check_field("tx_busy", want.busy, out_tdata[1]);
          check_field("send_rejected", want.rejected, out_tdata[2]);
          check_field("symbol_kind", want.kind, out_tdata[5:3]);
          check_field("received_byte", want.rx_byte, out_tdata[13:6]);
          check_field("parity_ok", want.parity_ok, out_tdata[14]);
          check_field("tdata fill", 0, out_tdata[15]);
          check_field("symbol_valid", want.sym_valid, out_tuser[0]);
          check_field("byte_valid", want.byte_valid, out_tuser[1]);
        end
      end
      if (cfg_wr_en) write_reg(cfg_index, cfg_wdata);
      if (in_tvalid && in_tready) status_due.push_back(step_link(in_tuser, in_tdata));
      pending <= status_due.size();
    end
  end

endmodule

// ----- sim/testbench.sv -----
// Testbench top for the infrared pulse-width transceiver: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module testbench;
  import irpw_pkg::*;

  // Command code the block leaves unused: it only reports status.
  localparam cmd_t CMD_UNUSED = 2'd3;
  // Long receiver hold-off, and the result count at which it starts.
  localparam int   LONG_HOLD  = 64;
  localparam int   HOLD_AT    = 300;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata   = '0;
  logic [1:0]            in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [15:0]           out_tdata;
  logic [1:0]            out_tuser;
  logic                  cfg_wr_en  = 1'b0;
  cfg_idx_t              cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  int fail_count;
  int pending;

  // Percent chance of an idle burst before a word or a receiver cycle.
  int idle_pct = 0;
  int words_sent = 0;

  // Window settings as last written, used to time the edges.
  int c_zero, c_one, c_start, c_stop;
  int win_above, win_below;

  ir_pulse_width_transceiver u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  irpw_result_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: far beyond the slowest legal run (every word and every result
  // stalled by the longest bursts).
  initial begin
    #10000000;
    $display("end of test: mismatches");
    $finish;
  end

  // Offer one word and hold it until the block takes it. An idle burst may
  // come first; valid stays high between back-to-back words.
  task automatic put_word(input cmd_t cmd, input logic [7:0] data);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  // Drop valid and wait until every result has come back. Every word yields
  // a result, so a short pause after the last one lets it reach the output register.
  task automatic settle();
    in_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all six registers back to back while the block is idle. Tolerance
  // writes carry random junk above bit 7, which the block must drop.
  task automatic set_windows(input int z, input int o, input int s, input int p,
                             input int above, input int below);
    logic [3:0] junk;
    junk = 4'($urandom_range(0, 15));
    c_zero    = z;
    c_one     = o;
    c_start   = s;
    c_stop    = p;
    win_above = above;
    win_below = below;
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_ZERO_CENTER;  cfg_wdata <= 12'(z); @(posedge clk);
    cfg_index <= REG_ONE_CENTER;   cfg_wdata <= 12'(o); @(posedge clk);
    cfg_index <= REG_START_CENTER; cfg_wdata <= 12'(s); @(posedge clk);
    cfg_index <= REG_STOP_CENTER;  cfg_wdata <= 12'(p); @(posedge clk);
    cfg_index <= REG_TOL_ABOVE;    cfg_wdata <= {junk, 8'(above)}; @(posedge clk);
    cfg_index <= REG_TOL_BELOW;    cfg_wdata <= {~junk, 8'(below)}; @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Run of carrier ticks; a few words become sends or unused commands, which
  // leave the edge interval alone; a send starts a frame if the transmitter is idle.
  task automatic tick_run(input int n, input int noise_pct);
    repeat (n) begin
      if ($urandom_range(0, 99) < noise_pct)
        put_word($urandom_range(0, 1) ? CMD_SEND : CMD_UNUSED, 8'($urandom));
      else
        put_word(CMD_TICK, 8'($urandom));
    end
  endtask

  // One received edge timed around a window center: mostly inside the
  // window (edges included), sometimes anywhere from zero up to center + 8.
  task automatic emit_symbol(input int center);
    int lo, hi, n;
    if ($urandom_range(0, 99) < 85) begin
      lo = center - ((win_below < 4) ? win_below : 4);
      hi = center + ((win_above < 4) ? win_above : 4);
      if (lo < 0) lo = 0;
      n = $urandom_range(hi, lo);
    end else begin
      n = $urandom_range(center + 8, 0);
    end
    tick_run(n, 3);
    put_word(CMD_EDGE, 8'($urandom));
  endtask

  // One receive frame. Shapes: 0 no start, 1 early stop, 2 overlong frame
  // that fills the receive store, 3 loose noise edges, else well formed.
  // Parity is wrong now and then.
  task automatic send_rx_frame(input int shape);
    logic [7:0] b;
    int nbits;
    b     = 8'($urandom);
    nbits = (shape == 1) ? $urandom_range(0, 7) : 8;
    if (shape == 3) begin
      repeat ($urandom_range(1, 4)) emit_symbol($urandom_range(c_stop + 4, 0));
    end else begin
      if (shape != 0) emit_symbol(c_start);
      for (int i = 0; i < nbits; i++) emit_symbol(b[i] ? c_one : c_zero);
      if (shape != 1) emit_symbol((b[0] ^ ($urandom_range(0, 4) == 0)) ? c_one : c_zero);
      if (shape == 2)
        repeat ($urandom_range(5, 10)) emit_symbol($urandom_range(0, 1) ? c_one : c_zero);
      emit_symbol(c_stop);
    end
  endtask

  // Result sink: random ready bursts, one long hold-off once results are
  // flowing, and no idling once the stimulus turns it off.
  initial begin : sink
    int  results;
    int  hold_left;
    bit  held;
    results = 0;
    held    = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && results >= HOLD_AT) begin
        // Hold off long enough for the output register to fill and stall input.
        held = 1'b1;
        out_tready <= 1'b0;
        for (hold_left = LONG_HOLD; hold_left > 0; hold_left--) @(posedge clk);
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
        if (out_tvalid) results++;
      end
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    int phase_end;
    c_zero    = RST_ZERO_CENTER;
    c_one     = RST_ONE_CENTER;
    c_start   = RST_START_CENTER;
    c_stop    = RST_STOP_CENTER;
    win_above = RST_TOL;
    win_below = RST_TOL;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words on reset settings: an edge with no ticks behind it,
    // the unused command, a tick while idle, an accepted send that turns the
    // carrier on at once, sends rejected while busy, data extremes.
    put_word(CMD_EDGE, 8'h00);
    put_word(CMD_UNUSED, 8'hFF);
    put_word(CMD_TICK, 8'hFF);
    put_word(CMD_SEND, 8'h00);
    put_word(CMD_SEND, 8'hFF);
    put_word(CMD_TICK, 8'h00);
    put_word(CMD_TICK, 8'h55);
    put_word(CMD_TICK, 8'hAA);
    put_word(CMD_EDGE, 8'hFF);
    put_word(CMD_UNUSED, 8'h00);
    put_word(CMD_SEND, 8'hA5);
    settle();

    // Reset-valued windows: one clean full-length receive frame. Its ticks
    // also carry the transmitter through the whole frame sent above, and
    // stray sends get rejected mid-frame.
    idle_pct = 25;
    set_windows(RST_ZERO_CENTER, RST_ONE_CENTER, RST_START_CENTER, RST_STOP_CENTER,
                RST_TOL, RST_TOL);
    send_rx_frame(9);
    settle();

    // Short windows keep receive frames cheap; walk through several
    // settings, extremes included.
    for (int ph = 0; ph < 5; ph++) begin
      idle_pct = (ph == 2) ? 0 : 25;
      case (ph)
        0: set_windows(2, 5, 8, 11, 1, 1);
        1: set_windows(0, 1, 2, 3, 0, 0);
        // Widest tolerance: every window overlaps, so zero always wins.
        2: set_windows(3, 3, 3, 3, 255, 255);
        // Windows out of order, lopsided tolerance.
        3: set_windows(6, 3, 9, 1, 2, 0);
        default: begin
          c_zero = $urandom_range(0, 3);
          set_windows(c_zero, c_zero + $urandom_range(1, 4), c_zero + $urandom_range(5, 8),
                      c_zero + $urandom_range(9, 12), $urandom_range(0, 1),
                      $urandom_range(0, 1));
        end
      endcase
      phase_end = words_sent + 20;
      while (words_sent < phase_end) send_rx_frame($urandom_range(0, 9));
      settle();
    end

    // Last part: no idling on either side.
    idle_pct = 0;
    set_windows(2, 5, 8, 11, 1, 1);
    phase_end = words_sent + 20;
    while (words_sent < phase_end) send_rx_frame($urandom_range(0, 9));
    settle();

    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/irpw_pkg.sv
rtl/core/ir_pulse_width_transceiver.sv
sim/irpw_result_checker.sv
sim/testbench.sv
